// File: hw/rtl/swsr_pkg.sv
// ----------------------------------------------------------------------------
// swsr_pkg: shared types and codes for the single-wire sensor reader
// Holds the sequencer phases, response status codes, configuration and
// result word layouts.
// ----------------------------------------------------------------------------
package swsr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_START_LOW  = 3'd1,
        PH_RESP_WAIT  = 3'd2,
        PH_RESP_CHECK = 3'd3,
        PH_RESP_END   = 3'd4,
        PH_BIT_HIGH   = 3'd5,
        PH_BIT_SAMPLE = 3'd6,
        PH_BIT_LOW    = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_PRESENT = 2'd1,
        ST_NONE    = 2'd2,
        ST_BAD     = 2'd3
    } status_t;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [2:0] REG_START_LOW      = 3'd0;
    localparam logic [2:0] REG_RESPONSE_DELAY = 3'd1;
    localparam logic [2:0] REG_RESPONSE_CHECK = 3'd2;
    localparam logic [2:0] REG_BIT_SAMPLE     = 3'd3;
    localparam logic [2:0] REG_BYTES_PER_FRM  = 3'd4;

    localparam logic [15:0] START_LOW_RST      = 16'd18000;
    localparam logic [15:0] RESPONSE_DELAY_RST = 16'd40;
    localparam logic [15:0] RESPONSE_CHECK_RST = 16'd80;
    localparam logic [15:0] BIT_SAMPLE_RST     = 16'd40;
    localparam logic [3:0]  BYTES_PER_FRM_RST  = 4'd5;

    typedef struct packed {
        logic [15:0] start_low_us;
        logic [15:0] response_delay_us;
        logic [15:0] response_check_us;
        logic [15:0] bit_sample_us;
        logic [3:0]  bytes_per_frame;
    } cfg_t;

    // One result word, first field in the highest bits
    typedef struct packed {
        logic        busy_res;
        status_t     response_status;
        logic        frame_last;
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        drive_low;
    } result_t;

endpackage

// File: hw/rtl/single_wire_sensor_reader.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_reader: single-wire humidity/temperature sensor receiver
// One input word per microsecond tick carries the start request and the
// sampled pin level; one result word per tick reports pin drive, bytes read
// and response status.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per microsecond tick, s_tdata[0] start_request,
//   s_tdata[1] pin_level. A start request aborts any read in progress.
//   m_ channel: exactly one result word per input word, in order. m_tlast
//   marks the last byte of a frame; m_tdata[1] flags a completed byte.
//   APB port: timing registers at 0x00..0x0C, frame length at 0x10; write
//   only while idle. Reads return the stored values.
// Output timing and throughput:
//   Each result word is registered (output register, or skid stage on a stall)
//   once its input word is taken; one word per cycle while s_tready is high.
//   The rate is set by the single state update per tick in the sequencer.
// Reset and stall:
//   aresetn (synchronous) returns the sequencer to idle, status pending,
//   and restores register defaults (18000, 40, 80, 40 us, 5 bytes).
//   When m_tready is low the output register holds its word and a skid
//   stage takes one more; s_tready drops only while the skid stage is full.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader #(
    parameter int COUNTER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_request, [1] pin_level, [7:2] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] drive_low, [1] byte_valid, [9:2] data_byte,
                                   // [11:10] response_status, [12] busy_res, [15:13] zero
    output logic        m_tlast,   // frame_last
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    swsr_pkg::cfg_t    cfg_reg;
    swsr_pkg::result_t core_res;
    swsr_pkg::result_t out_reg, out_next;
    swsr_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              in_take;
    logic              out_free;
    logic              cfg_write;
    logic [2:0]        reg_idx;

    // ---------------- configuration registers ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_us      <= swsr_pkg::START_LOW_RST;
            cfg_reg.response_delay_us <= swsr_pkg::RESPONSE_DELAY_RST;
            cfg_reg.response_check_us <= swsr_pkg::RESPONSE_CHECK_RST;
            cfg_reg.bit_sample_us     <= swsr_pkg::BIT_SAMPLE_RST;
            cfg_reg.bytes_per_frame   <= swsr_pkg::BYTES_PER_FRM_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                swsr_pkg::REG_START_LOW:      cfg_reg.start_low_us      <= pwdata[15:0];
                swsr_pkg::REG_RESPONSE_DELAY: cfg_reg.response_delay_us <= pwdata[15:0];
                swsr_pkg::REG_RESPONSE_CHECK: cfg_reg.response_check_us <= pwdata[15:0];
                swsr_pkg::REG_BIT_SAMPLE:     cfg_reg.bit_sample_us     <= pwdata[15:0];
                swsr_pkg::REG_BYTES_PER_FRM:  cfg_reg.bytes_per_frame   <= pwdata[3:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            swsr_pkg::REG_START_LOW:      prdata = {16'd0, cfg_reg.start_low_us};
            swsr_pkg::REG_RESPONSE_DELAY: prdata = {16'd0, cfg_reg.response_delay_us};
            swsr_pkg::REG_RESPONSE_CHECK: prdata = {16'd0, cfg_reg.response_check_us};
            swsr_pkg::REG_BIT_SAMPLE:     prdata = {16'd0, cfg_reg.bit_sample_us};
            swsr_pkg::REG_BYTES_PER_FRM:  prdata = {28'd0, cfg_reg.bytes_per_frame};
            default:                      prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer ----------------
    // Take a word whenever the skid stage is empty; the sequencer advances
    // one tick per taken word.
    assign s_tready = !skid_valid_reg;
    assign in_take  = s_tvalid && s_tready;

    swsr_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick          (in_take),
        .start_request (s_tdata[0]),
        .pin_level     (s_tdata[1]),
        .cfg           (cfg_reg),
        .result        (core_res)
    );

    // ---------------- output register and skid stage ----------------
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                // drain the held word first; no new word is taken this cycle
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (in_take) begin
                out_next       = core_res;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (in_take) begin
            // receiver stalled: park the new word in the skid stage
            skid_next       = core_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.frame_last;
    assign m_tdata  = {3'd0, out_reg.busy_res, out_reg.response_status, out_reg.data_byte,
                       out_reg.byte_valid, out_reg.drive_low};

endmodule

// File: hw/rtl/swsr_core.sv
// ----------------------------------------------------------------------------
// swsr_core: reader sequencer
// Advances the phase, timer and byte assembly by one tick per accepted word
// and forms that tick's result word.
// ----------------------------------------------------------------------------
module swsr_core #(
    parameter int COUNTER_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tick,
    input  logic              start_request,
    input  logic              pin_level,
    input  swsr_pkg::cfg_t    cfg,
    output swsr_pkg::result_t result
);

    localparam int TW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
    localparam logic [COUNTER_BITS-1:0] CMAX = {COUNTER_BITS{1'b1}};
    localparam logic [TW-1:0] CMAX_W = TW'(CMAX);

    swsr_pkg::phase_t        phase_reg, phase_next;
    swsr_pkg::status_t       status_reg, status_next;
    logic [COUNTER_BITS-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic [7:0]              shift_reg, shift_next;
    logic [2:0]              bit_idx_reg, bit_idx_next;
    logic [2:0]              byte_idx_reg, byte_idx_next;

    logic [15:0]   tgt_sel, tgt_min1;
    logic [TW-1:0] tgt_w, tgt_eff;
    logic          timer_done;
    logic [3:0]    frame_len;
    logic          frame_end;
    logic          valid_c;
    logic          last_c;
    logic [7:0]    data_c;

    // Saturating timer, target taken as at least one tick and clamped to range
    always_comb begin
        case (phase_reg)
            swsr_pkg::PH_START_LOW:  tgt_sel = cfg.start_low_us;
            swsr_pkg::PH_RESP_WAIT:  tgt_sel = cfg.response_delay_us;
            swsr_pkg::PH_RESP_CHECK: tgt_sel = cfg.response_check_us;
            default:                 tgt_sel = cfg.bit_sample_us;
        endcase
        tgt_min1    = (tgt_sel == 16'd0) ? 16'd1 : tgt_sel;
        tgt_w       = TW'(tgt_min1);
        tgt_eff     = (tgt_w > CMAX_W) ? CMAX_W : tgt_w;
        elapsed_inc = (elapsed_reg == CMAX) ? elapsed_reg
                                            : elapsed_reg + COUNTER_BITS'(1);
        timer_done  = TW'(elapsed_inc) >= tgt_eff;
    end

    // Frame length clamped to 1..8 bytes
    always_comb begin
        if (cfg.bytes_per_frame == 4'd0) begin
            frame_len = 4'd1;
        end else if (cfg.bytes_per_frame > 4'd8) begin
            frame_len = 4'd8;
        end else begin
            frame_len = cfg.bytes_per_frame;
        end
        frame_end = ({1'b0, byte_idx_reg} + 4'd1) >= frame_len;
    end

    // Next state
    always_comb begin
        phase_next    = phase_reg;
        status_next   = status_reg;
        elapsed_next  = elapsed_reg;
        shift_next    = shift_reg;
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        valid_c       = 1'b0;
        last_c        = 1'b0;
        data_c        = 8'd0;
        if (start_request) begin
            phase_next    = swsr_pkg::PH_START_LOW;
            status_next   = swsr_pkg::ST_PENDING;
            elapsed_next  = '0;
            shift_next    = 8'd0;
            bit_idx_next  = 3'd0;
            byte_idx_next = 3'd0;
        end else begin
            case (phase_reg)
                swsr_pkg::PH_START_LOW: begin
                    elapsed_next = elapsed_inc;
                    if (timer_done) begin
                        phase_next   = swsr_pkg::PH_RESP_WAIT;
                        elapsed_next = '0;
                    end
                end
                swsr_pkg::PH_RESP_WAIT: begin
                    elapsed_next = elapsed_inc;
                    if (timer_done) begin
                        if (pin_level) begin
                            status_next = swsr_pkg::ST_NONE;
                            phase_next  = swsr_pkg::PH_RESP_END;
                        end else begin
                            phase_next   = swsr_pkg::PH_RESP_CHECK;
                            elapsed_next = '0;
                        end
                    end
                end
                swsr_pkg::PH_RESP_CHECK: begin
                    elapsed_next = elapsed_inc;
                    if (timer_done) begin
                        status_next = pin_level ? swsr_pkg::ST_PRESENT : swsr_pkg::ST_BAD;
                        phase_next  = swsr_pkg::PH_RESP_END;
                    end
                end
                swsr_pkg::PH_RESP_END: begin
                    if (!pin_level) begin
                        phase_next = (status_reg == swsr_pkg::ST_PRESENT) ?
                                     swsr_pkg::PH_BIT_HIGH : swsr_pkg::PH_IDLE;
                    end
                end
                swsr_pkg::PH_BIT_HIGH: begin
                    if (pin_level) begin
                        phase_next   = swsr_pkg::PH_BIT_SAMPLE;
                        elapsed_next = '0;
                    end
                end
                swsr_pkg::PH_BIT_SAMPLE: begin
                    elapsed_next = elapsed_inc;
                    if (timer_done) begin
                        shift_next = {shift_reg[6:0], pin_level};
                        phase_next = swsr_pkg::PH_BIT_LOW;
                    end
                end
                swsr_pkg::PH_BIT_LOW: begin
                    if (!pin_level) begin
                        phase_next = swsr_pkg::PH_BIT_HIGH;
                        if (bit_idx_reg == 3'd7) begin
                            bit_idx_next = 3'd0;
                            valid_c      = 1'b1;
                            data_c       = shift_reg;
                            shift_next   = 8'd0;
                            if (frame_end) begin
                                last_c        = 1'b1;
                                byte_idx_next = 3'd0;
                                phase_next    = swsr_pkg::PH_IDLE;
                            end else begin
                                byte_idx_next = byte_idx_reg + 3'd1;
                            end
                        end else begin
                            bit_idx_next = bit_idx_reg + 3'd1;
                        end
                    end
                end
                default: begin
                    phase_next = swsr_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Result word for this tick
    always_comb begin
        result.drive_low       = (phase_next == swsr_pkg::PH_START_LOW);
        result.byte_valid      = valid_c;
        result.data_byte       = data_c;
        result.frame_last      = last_c;
        result.response_status = status_next;
        result.busy_res        = (phase_next != swsr_pkg::PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= swsr_pkg::PH_IDLE;
            status_reg   <= swsr_pkg::ST_PENDING;
            elapsed_reg  <= '0;
            shift_reg    <= 8'd0;
            bit_idx_reg  <= 3'd0;
            byte_idx_reg <= 3'd0;
        end else if (tick) begin
            phase_reg    <= phase_next;
            status_reg   <= status_next;
            elapsed_reg  <= elapsed_next;
            shift_reg    <= shift_next;
            bit_idx_reg  <= bit_idx_next;
            byte_idx_reg <= byte_idx_next;
        end
    end

endmodule

// File: hw/rtl/swsr_checker.sv
// ----------------------------------------------------------------------------
// swsr_checker: port-level checks for the single-wire sensor reader
// Watches the result stream for stall behavior and field consistency.
// ----------------------------------------------------------------------------
module swsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // hold a stalled word
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_last_is_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[1])
        else $error("frame end without a completed byte");

    a_no_byte_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> (m_tdata[9:2] == 8'd0) && !m_tlast)
        else $error("byte fields set without a completed byte");

    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[12])
        else $error("pin driven low while not busy");

endmodule

bind single_wire_sensor_reader swsr_checker u_swsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
